>>> design/tls_pkg.sv
package tls_pkg;

    localparam int DEF_LINE_SLOTS = 512;
    localparam int DEF_LINE_BYTES = 256;

    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;

    localparam logic [OP_W-1:0] OP_DATA  = 3'd0;
    localparam logic [OP_W-1:0] OP_EOS   = 3'd1;
    localparam logic [OP_W-1:0] OP_SORT  = 3'd2;
    localparam logic [OP_W-1:0] OP_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

    // datapath commands, one per controller step
    typedef logic [4:0] cmd_t;

    localparam cmd_t CMD_NONE      = 5'd0;
    localparam cmd_t CMD_ACCEPT    = 5'd1;
    localparam cmd_t CMD_SORT_RD_I = 5'd2;
    localparam cmd_t CMD_SORT_CUR  = 5'd3;
    localparam cmd_t CMD_SORT_CLEN = 5'd4;
    localparam cmd_t CMD_SORT_RD_J = 5'd5;
    localparam cmd_t CMD_SORT_PREV = 5'd6;
    localparam cmd_t CMD_SORT_PLEN = 5'd7;
    localparam cmd_t CMD_CMP_RD    = 5'd8;
    localparam cmd_t CMD_CMP_NEXT  = 5'd9;
    localparam cmd_t CMD_SHIFT     = 5'd10;
    localparam cmd_t CMD_PLACE     = 5'd11;
    localparam cmd_t CMD_SORT_DONE = 5'd12;
    localparam cmd_t CMD_RD_ORD    = 5'd13;
    localparam cmd_t CMD_RD_LEN    = 5'd14;
    localparam cmd_t CMD_RD_BASE   = 5'd15;
    localparam cmd_t CMD_RD_TXT    = 5'd16;
    localparam cmd_t CMD_RD_BYTE   = 5'd17;
    localparam cmd_t CMD_RD_NL     = 5'd18;
    localparam cmd_t CMD_FIN_LOAD  = 5'd19;

    typedef struct packed {
        logic ovf;
        logic rd_avail;
        logic sort_more;
        logic j_zero;
        logic k_lt_m;
        logic plen_gt;
        logic bytes_ne;
        logic a_gt_b;
        logic pos_lt_len;
        logic out_free;
    } stat_t;

endpackage

>>> design/tls_ctrl.sv
module tls_ctrl
    import tls_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic [OP_W-1:0] op,
    input  stat_t           stat,
    output logic            s_tready,
    output cmd_t            cmd
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_FIN    = 5'd1;
    localparam logic [4:0] ST_I      = 5'd2;
    localparam logic [4:0] ST_CUR    = 5'd3;
    localparam logic [4:0] ST_CLEN   = 5'd4;
    localparam logic [4:0] ST_J      = 5'd5;
    localparam logic [4:0] ST_PREV   = 5'd6;
    localparam logic [4:0] ST_PLEN   = 5'd7;
    localparam logic [4:0] ST_CMP    = 5'd8;
    localparam logic [4:0] ST_CMPW   = 5'd9;
    localparam logic [4:0] ST_SHIFT  = 5'd10;
    localparam logic [4:0] ST_PLACE  = 5'd11;
    localparam logic [4:0] ST_R_ORD  = 5'd12;
    localparam logic [4:0] ST_R_LEN  = 5'd13;
    localparam logic [4:0] ST_R_BASE = 5'd14;
    localparam logic [4:0] ST_R_TXT  = 5'd15;
    localparam logic [4:0] ST_R_BYTE = 5'd16;

    logic [4:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd = CMD_ACCEPT;
                    if (op == OP_SORT && !stat.ovf)
                        state_next = ST_I;
                    else if (op == OP_READ && !stat.ovf && stat.rd_avail)
                        state_next = ST_R_ORD;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd        = CMD_FIN_LOAD;
                    state_next = ST_IDLE;
                end
            end
            ST_I:
            begin
                if (stat.sort_more)
                begin
                    cmd        = CMD_SORT_RD_I;
                    state_next = ST_CUR;
                end
                else
                begin
                    cmd        = CMD_SORT_DONE;
                    state_next = ST_FIN;
                end
            end
            ST_CUR:
            begin
                cmd        = CMD_SORT_CUR;
                state_next = ST_CLEN;
            end
            ST_CLEN:
            begin
                cmd        = CMD_SORT_CLEN;
                state_next = ST_J;
            end
            ST_J:
            begin
                if (stat.j_zero)
                    state_next = ST_PLACE;
                else
                begin
                    cmd        = CMD_SORT_RD_J;
                    state_next = ST_PREV;
                end
            end
            ST_PREV:
            begin
                cmd        = CMD_SORT_PREV;
                state_next = ST_PLEN;
            end
            ST_PLEN:
            begin
                cmd        = CMD_SORT_PLEN;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.k_lt_m)
                begin
                    cmd        = CMD_CMP_RD;
                    state_next = ST_CMPW;
                end
                else if (stat.plen_gt)
                    state_next = ST_SHIFT;
                else
                    state_next = ST_PLACE;
            end
            ST_CMPW:
            begin
                if (stat.bytes_ne)
                    state_next = stat.a_gt_b ? ST_SHIFT : ST_PLACE;
                else
                begin
                    cmd        = CMD_CMP_NEXT;
                    state_next = ST_CMP;
                end
            end
            ST_SHIFT:
            begin
                cmd        = CMD_SHIFT;
                state_next = ST_J;
            end
            ST_PLACE:
            begin
                cmd        = CMD_PLACE;
                state_next = ST_I;
            end
            ST_R_ORD:
            begin
                cmd        = CMD_RD_ORD;
                state_next = ST_R_LEN;
            end
            ST_R_LEN:
            begin
                cmd        = CMD_RD_LEN;
                state_next = ST_R_BASE;
            end
            ST_R_BASE:
            begin
                cmd        = CMD_RD_BASE;
                state_next = ST_R_TXT;
            end
            ST_R_TXT:
            begin
                if (stat.pos_lt_len)
                begin
                    cmd        = CMD_RD_TXT;
                    state_next = ST_R_BYTE;
                end
                else
                begin
                    cmd        = CMD_RD_NL;
                    state_next = ST_FIN;
                end
            end
            ST_R_BYTE:
            begin
                cmd        = CMD_RD_BYTE;
                state_next = ST_FIN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> design/tls_dpath.sv
module tls_dpath
    import tls_pkg::*;
#(
    parameter int LINE_SLOTS = DEF_LINE_SLOTS,
    parameter int LINE_BYTES = DEF_LINE_BYTES,
    parameter int CNT_W      = $clog2(LINE_SLOTS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic [OP_W-1:0]   op,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              m_tready,
    output stat_t             stat,
    output logic              m_tvalid,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_valid,
    output logic              out_last,
    output logic              status,
    output logic [CNT_W-1:0]  lines_held
);

    localparam int ROW     = LINE_BYTES - 1;
    localparam int SLOT_W  = $clog2(LINE_SLOTS);
    localparam int LEN_W   = $clog2(LINE_BYTES);
    localparam int TDEPTH  = LINE_SLOTS * ROW;
    localparam int TADDR_W = $clog2(TDEPTH);

    logic [BYTE_W-1:0] text_mem [TDEPTH];
    logic [LEN_W-1:0]  len_mem  [LINE_SLOTS];
    logic [SLOT_W-1:0] ord_mem  [LINE_SLOTS];

    logic [CNT_W-1:0]   total_reg, total_next;
    logic [LEN_W-1:0]   partial_reg, partial_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   rlp_reg, rlp_next;
    logic [LEN_W-1:0]   rbp_reg, rbp_next;
    logic [TADDR_W-1:0] line_base_reg, line_base_next;
    logic [LEN_W-1:0]   cur_len_reg, cur_len_next;
    logic               zero_seen_reg, zero_seen_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [SLOT_W-1:0]  prev_reg, prev_next;
    logic [LEN_W-1:0]   clen_reg, clen_next;
    logic [LEN_W-1:0]   plen_reg, plen_next;
    logic [LEN_W-1:0]   mlen_reg, mlen_next;
    logic [LEN_W-1:0]   k_reg, k_next;
    logic [LEN_W-1:0]   rlen_reg, rlen_next;
    logic [TADDR_W-1:0] cur_base_reg, cur_base_next;
    logic [TADDR_W-1:0] a_base_reg, a_base_next;
    logic [BYTE_W-1:0]  res_byte_reg, res_byte_next;
    logic               res_valid_reg, res_valid_next;
    logic               res_last_reg, res_last_next;
    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  m_byte_reg, m_byte_next;
    logic               m_ovalid_reg, m_ovalid_next;
    logic               m_last_reg, m_last_next;
    logic               m_status_reg, m_status_next;
    logic [CNT_W-1:0]   m_lines_reg, m_lines_next;

    logic [SLOT_W-1:0]  ord_q;
    logic [LEN_W-1:0]   len_q;
    logic [BYTE_W-1:0]  txt_a_q, txt_b_q;
    logic [SLOT_W-1:0]  ord_raddr;
    logic [TADDR_W-1:0] ta_addr, tb_addr, ord_base;
    logic               do_close;
    logic               ord_we, len_we, txt_we;
    logic [SLOT_W-1:0]  ord_waddr, ord_wdata;
    logic               out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign ord_base = TADDR_W'(ord_q) * TADDR_W'(ROW);
    assign tb_addr  = cur_base_reg + TADDR_W'(k_reg);
    assign ta_addr  = (cmd == CMD_RD_TXT) ? a_base_reg + TADDR_W'(rbp_reg)
                                          : a_base_reg + TADDR_W'(k_reg);

    always_comb
    begin
        case (cmd)
            CMD_SORT_RD_I: ord_raddr = i_reg[SLOT_W-1:0];
            CMD_SORT_RD_J: ord_raddr = SLOT_W'(j_reg - CNT_W'(1));
            default:       ord_raddr = rlp_reg[SLOT_W-1:0];
        endcase
    end

    assign stat.ovf        = ovf_reg;
    assign stat.rd_avail   = rlp_reg < total_reg;
    assign stat.sort_more  = i_reg < total_reg;
    assign stat.j_zero     = (j_reg == '0);
    assign stat.k_lt_m     = k_reg < mlen_reg;
    assign stat.plen_gt    = plen_reg > clen_reg;
    assign stat.bytes_ne   = txt_a_q != txt_b_q;
    assign stat.a_gt_b     = txt_a_q > txt_b_q;
    assign stat.pos_lt_len = rbp_reg < rlen_reg;
    assign stat.out_free   = out_free;

    always_comb
    begin
        total_next     = total_reg;
        partial_next   = partial_reg;
        ovf_next       = ovf_reg;
        rlp_next       = rlp_reg;
        rbp_next       = rbp_reg;
        line_base_next = line_base_reg;
        cur_len_next   = cur_len_reg;
        zero_seen_next = zero_seen_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        clen_next      = clen_reg;
        plen_next      = plen_reg;
        mlen_next      = mlen_reg;
        k_next         = k_reg;
        rlen_next      = rlen_reg;
        cur_base_next  = cur_base_reg;
        a_base_next    = a_base_reg;
        res_byte_next  = res_byte_reg;
        res_valid_next = res_valid_reg;
        res_last_next  = res_last_reg;
        m_valid_next   = m_valid_reg;
        m_byte_next    = m_byte_reg;
        m_ovalid_next  = m_ovalid_reg;
        m_last_next    = m_last_reg;
        m_status_next  = m_status_reg;
        m_lines_next   = m_lines_reg;
        do_close       = 1'b0;
        ord_we         = 1'b0;
        len_we         = 1'b0;
        txt_we         = 1'b0;
        ord_waddr      = j_reg[SLOT_W-1:0];
        ord_wdata      = cur_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (cmd)
            CMD_ACCEPT:
            begin
                res_byte_next  = '0;
                res_valid_next = 1'b0;
                res_last_next  = 1'b0;
                i_next         = CNT_W'(1);
                case (op)
                    OP_DATA:
                    begin
                        if (data_byte == NEWLINE || partial_reg == LEN_W'(ROW))
                            do_close = 1'b1;
                        else
                        begin
                            if (total_reg < CNT_W'(LINE_SLOTS))
                            begin
                                txt_we = 1'b1;
                                if (data_byte == '0)
                                    zero_seen_next = 1'b1;
                                else if (!zero_seen_reg)
                                    cur_len_next = partial_reg + LEN_W'(1);
                            end
                            partial_next = partial_reg + LEN_W'(1);
                        end
                    end
                    OP_EOS:
                    begin
                        if (partial_reg != '0)
                            do_close = 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        total_next     = '0;
                        partial_next   = '0;
                        ovf_next       = 1'b0;
                        rlp_next       = '0;
                        rbp_next       = '0;
                        line_base_next = '0;
                        cur_len_next   = '0;
                        zero_seen_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_SORT_CUR:
            begin
                cur_next      = ord_q;
                cur_base_next = ord_base;
            end
            CMD_SORT_CLEN:
            begin
                clen_next = len_q;
                j_next    = i_reg;
            end
            CMD_SORT_PREV:
            begin
                prev_next   = ord_q;
                a_base_next = ord_base;
            end
            CMD_SORT_PLEN:
            begin
                plen_next = len_q;
                mlen_next = (len_q < clen_reg) ? len_q : clen_reg;
                k_next    = '0;
            end
            CMD_CMP_NEXT:
            begin
                k_next = k_reg + LEN_W'(1);
            end
            CMD_SHIFT:
            begin
                ord_we    = 1'b1;
                ord_wdata = prev_reg;
                j_next    = j_reg - CNT_W'(1);
            end
            CMD_PLACE:
            begin
                ord_we = 1'b1;
                i_next = i_reg + CNT_W'(1);
            end
            CMD_SORT_DONE:
            begin
                rlp_next = '0;
                rbp_next = '0;
            end
            CMD_RD_LEN:
            begin
                a_base_next = ord_base;
            end
            CMD_RD_BASE:
            begin
                rlen_next = len_q;
            end
            CMD_RD_BYTE:
            begin
                res_byte_next  = txt_a_q;
                res_valid_next = 1'b1;
                rbp_next       = rbp_reg + LEN_W'(1);
            end
            CMD_RD_NL:
            begin
                res_byte_next  = NEWLINE;
                res_valid_next = 1'b1;
                res_last_next  = (rlp_reg + CNT_W'(1)) == total_reg;
                rlp_next       = rlp_reg + CNT_W'(1);
                rbp_next       = '0;
            end
            CMD_FIN_LOAD:
            begin
                m_valid_next  = 1'b1;
                m_byte_next   = res_byte_reg;
                m_ovalid_next = res_valid_reg;
                m_last_next   = res_last_reg;
                m_status_next = ovf_reg;
                m_lines_next  = total_reg;
            end
            default:
            begin
            end
        endcase

        // line close: either stored with its length or counted as overflow
        if (do_close)
        begin
            if (total_reg >= CNT_W'(LINE_SLOTS))
                ovf_next = 1'b1;
            else
            begin
                len_we         = 1'b1;
                ord_we         = 1'b1;
                ord_waddr      = total_reg[SLOT_W-1:0];
                ord_wdata      = total_reg[SLOT_W-1:0];
                total_next     = total_reg + CNT_W'(1);
                line_base_next = line_base_reg + TADDR_W'(ROW);
            end
            partial_next   = '0;
            cur_len_next   = '0;
            zero_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (txt_we)
            text_mem[line_base_reg + TADDR_W'(partial_reg)] <= data_byte;
        if (len_we)
            len_mem[total_reg[SLOT_W-1:0]] <= cur_len_reg;
        if (ord_we)
            ord_mem[ord_waddr] <= ord_wdata;
        txt_a_q <= text_mem[ta_addr];
        txt_b_q <= text_mem[tb_addr];
        ord_q   <= ord_mem[ord_raddr];
        len_q   <= len_mem[ord_q];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            partial_reg   <= '0;
            ovf_reg       <= 1'b0;
            rlp_reg       <= '0;
            rbp_reg       <= '0;
            line_base_reg <= '0;
            cur_len_reg   <= '0;
            zero_seen_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            partial_reg   <= partial_next;
            ovf_reg       <= ovf_next;
            rlp_reg       <= rlp_next;
            rbp_reg       <= rbp_next;
            line_base_reg <= line_base_next;
            cur_len_reg   <= cur_len_next;
            zero_seen_reg <= zero_seen_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        clen_reg      <= clen_next;
        plen_reg      <= plen_next;
        mlen_reg      <= mlen_next;
        rlen_reg      <= rlen_next;
        cur_base_reg  <= cur_base_next;
        a_base_reg    <= a_base_next;
        res_byte_reg  <= res_byte_next;
        res_valid_reg <= res_valid_next;
        res_last_reg  <= res_last_next;
        m_byte_reg    <= m_byte_next;
        m_ovalid_reg  <= m_ovalid_next;
        m_last_reg    <= m_last_next;
        m_status_reg  <= m_status_next;
        m_lines_reg   <= m_lines_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign out_byte   = m_byte_reg;
    assign out_valid  = m_ovalid_reg;
    assign out_last   = m_last_reg;
    assign status     = m_status_reg;
    assign lines_held = m_lines_reg;

`ifndef SYNTH
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(LINE_SLOTS))
        else $error("line count past slot count");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_len_reg <= partial_reg)
        else $error("stored length past partial length");

    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_FIN_LOAD) |-> out_free)
        else $error("result loaded over a pending transaction");

    a_read_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_RD_BYTE) |=> (rbp_reg != '0))
        else $error("byte position did not advance");
`endif

endmodule

>>> design/text_line_sorter_core.sv
// Text line sorter: gathers bytes into lines, sorts lines, streams them back.
// Input channel s_*: s_tuser = operation (data, end of source, sort, read,
// clear), s_tdata = data byte. Every input transaction yields exactly one
// result transaction on m_*, in order.
// Data, end of source, clear, unused codes, and a sort or read under
// overflow or with no line left to read are accepted, then their result
// is loaded. A read goes through the order, length and text memories back
// to back, each with a registered output. A sort runs an insertion sort on
// the line order table, comparing byte pairs until they differ or the shorter
// line ends; a sort of n lines is on the order of n*n/2 comparisons.
// The result register decouples the sides: a new transaction is accepted
// while the previous result still waits for m_tready; the block only holds
// off in the final step if that result has not left yet.
// Reset clears the counters and the overflow, zero-byte and output valid
// flags; text, length and order memories hold no reset value and are only
// read where written since the last clear, so no clearing pass is needed.
module text_line_sorter_core
    import tls_pkg::*;
#(
    parameter int LINE_SLOTS = DEF_LINE_SLOTS,
    parameter int LINE_BYTES = DEF_LINE_BYTES,
    parameter int CNT_W      = $clog2(LINE_SLOTS + 1),
    parameter int M_DATA_W   = ((BYTE_W + CNT_W + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic [OP_W-1:0]     s_tuser,   // [2:0] operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_byte, lines_held, zero pad
    output logic                m_tlast,   // out_last
    output logic [1:0]          m_tuser    // [0] out_valid, [1] status
);

    cmd_t              cmd;
    stat_t             stat;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              status;
    logic [CNT_W-1:0]  lines_held;

    tls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    tls_dpath #(
        .LINE_SLOTS (LINE_SLOTS),
        .LINE_BYTES (LINE_BYTES),
        .CNT_W      (CNT_W)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .op         (s_tuser),
        .data_byte  (s_tdata),
        .m_tready   (m_tready),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .out_byte   (out_byte),
        .out_valid  (out_valid),
        .out_last   (m_tlast),
        .status     (status),
        .lines_held (lines_held)
    );

    // pack result fields, lowest first
    assign m_tdata = M_DATA_W'({lines_held, out_byte});
    assign m_tuser = {status, out_valid};

endmodule
